FILE: hw/rtl/lkvc_pkg.sv
// lkvc_pkg: shared constants, opcodes and cell interface types for the LRU key-value cache.
// No dependencies; imported by lkvc_cell and lru_key_value_cache.

package lkvc_pkg;

   localparam int DEPTH  = 16;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int KEY_W  = 32;
   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;

   localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
   localparam logic [DATA_W-1:0] MISS_DATA = '1;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] data;
   } entry_type;

   typedef struct packed {
      logic              found;
      logic [DATA_W-1:0] data;
   } lookup_type;

   typedef struct packed {
      logic move;
      logic fill;
   } cell_ctrl_type;

endpackage

FILE: hw/rtl/lkvc_cell.sv
// lkvc_cell: one recency position of the LRU chain, holding a key/data entry.
// Compares against the request key, forwards lookup results leftward and
// entries rightward. Depends on lkvc_pkg.

module lkvc_cell
   import lkvc_pkg::*;
(
   input  logic             clock,
   input  logic             occupied,
   input  logic [KEY_W-1:0] cmp_key,
   input  cell_ctrl_type    ctrl,
   input  entry_type        entry_left,
   output entry_type        entry_right,
   input  lookup_type       lkup_right,
   output lookup_type       lkup_left,
   output logic             match
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      shift;

   always_comb begin
      match = occupied && (entry_ff.key == cmp_key);
      if (match) begin
         lkup_left.found = 1'b1;
         lkup_left.data  = entry_ff.data;
      end else begin
         lkup_left = lkup_right;
      end
      shift    = (ctrl.move && lkup_left.found) || ctrl.fill;
      entry_in = shift ? entry_left : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_right = entry_ff;

endmodule

FILE: hw/rtl/lru_key_value_cache.sv
// lru_key_value_cache: fully associative key-value store with LRU replacement.
// Top level; instantiates a row of lkvc_cell, depends on lkvc_pkg.
//
// Usage:
//   Request channel (req_*): opcode selects get or put of req_key; a put
//   stores req_data_in. Response channel (rsp_*): one transaction per get,
//   none per put, with rsp_hit and rsp_data_out (all ones on a miss).
//   Configuration (csr_*): csr_wr_data sets the capacity, written while idle;
//   values above the cell count act as the full cell count, zero blocks puts.
// Latency and throughput:
//   A get's response is valid the cycle after the request is accepted. One
//   request is accepted every cycle unless stalled; the combinational path is
//   the parallel key compare feeding the found chain across all cells into the
//   shift enables. Cells are kept in recency order, most recent at cell 0.
// Reset:
//   The entry count goes to zero and the capacity to 16; the cells need no
//   clearing, since occupancy follows from the count.
// Stall:
//   While a response waits under rsp_stall, req_stall is raised and the
//   response register holds.

module lru_key_value_cache
   import lkvc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_opcode,
   input  logic signed [KEY_W-1:0]  req_key,
   input  logic signed [DATA_W-1:0] req_data_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_hit,
   output logic signed [DATA_W-1:0] rsp_data_out,
   input  logic                     csr_wr_en,
   input  logic [CAP_W-1:0]         csr_wr_data
);

   logic [CAP_W-1:0]  capacity_ff, capacity_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              is_put;
   logic              hit;
   logic              cap_zero;
   logic              evict;
   logic              move;
   logic              insert;
   logic [CNT_W-1:0]  eff_cap;
   logic [CNT_W-1:0]  new_count;
   entry_type         head;

   entry_type     entry_chain [DEPTH+1];
   lookup_type    lkup_chain  [DEPTH+1];
   cell_ctrl_type ctrl        [DEPTH];
   logic [DEPTH-1:0] match_vec;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_put    = (req_opcode == OP_PUT);
   assign hit       = lkup_chain[0].found;

   always_comb begin
      eff_cap   = (int'(capacity_ff) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(capacity_ff);
      cap_zero  = (eff_cap == '0);
      evict     = (count_ff >= eff_cap);
      new_count = evict ? count_ff : CNT_W'(count_ff + 1'b1);
      move      = accept && hit && (!is_put || !cap_zero);
      insert    = accept && is_put && !cap_zero && !hit;
      count_in  = insert ? new_count : count_ff;

      head.key  = req_key;
      head.data = is_put ? req_data_in : lkup_chain[0].data;

      capacity_in = csr_wr_en ? csr_wr_data : capacity_ff;

      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept && !is_put) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit;
         rsp_data_in  = hit ? lkup_chain[0].data : MISS_DATA;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign entry_chain[0]    = head;
   assign lkup_chain[DEPTH] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign ctrl[i].move = move;
      assign ctrl[i].fill = insert && (CNT_W'(i) < new_count);

      lkvc_cell u_cell (
         .clock       (clock),
         .occupied    (CNT_W'(i) < count_ff),
         .cmp_key     (req_key),
         .ctrl        (ctrl[i]),
         .entry_left  (entry_chain[i]),
         .entry_right (entry_chain[i+1]),
         .lkup_right  (lkup_chain[i+1]),
         .lkup_left   (lkup_chain[i]),
         .match       (match_vec[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_hit_ff  <= rsp_hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_data_out = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= DEPTH)
      else $error("entry count exceeds cell count");

   a_keys_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("request key matches more than one cell");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      insert |=> (count_ff != '0))
      else $error("count empty after insert");

   a_miss_resp: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_put && !hit) |=> (rsp_valid_ff && !rsp_hit_ff && rsp_data_ff == MISS_DATA))
      else $error("miss response not formed");

endmodule
